### src/tsd_pkg.sv
// Package for the two-stack deque: sizes, item and status codes, and the
// structs passed between the request and response sides. No dependencies.
`default_nettype none

package tsd_pkg;

   localparam int DATA_W      = 32;
   localparam int STACK_DEPTH = 256;
   localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int TOT_W       = CNT_W + 1;

   localparam int KIND_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 9;
   localparam int RDATA_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 10;

   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH_FRONT = 3'd0,
      KIND_PUSH_BACK  = 3'd1,
      KIND_READ_INDEX = 3'd2,
      KIND_READ_FRONT = 3'd3,
      KIND_READ_BACK  = 3'd4
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [DATA_W-1:0] wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } mem_cmd_type;

   typedef struct packed {
      logic             use_mem;
      logic             from_front;
      status_type       status;
      logic [TOT_W-1:0] count;
   } pend_type;

endpackage

`default_nettype wire

### src/tsd_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// Read data holds when no read is issued. No dependencies.
`default_nettype none

module tsd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

### src/tsd_ctrl.sv
// Request side of the two-stack deque: decodes each beat, keeps the stack
// counts, issues the memory accesses and records the pending result. Uses tsd_pkg.
`default_nettype none

module tsd_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          accept,
   input  wire logic [tsd_pkg::KIND_W-1:0]    req_kind,
   input  wire logic [tsd_pkg::VALUE_W-1:0]   req_value,
   input  wire logic [tsd_pkg::POS_W-1:0]     req_position,
   output tsd_pkg::mem_cmd_type               front_cmd,
   output tsd_pkg::mem_cmd_type               back_cmd,
   output tsd_pkg::pend_type                  pend_in
);

   import tsd_pkg::*;

   logic [CNT_W-1:0] front_count_ff, front_count_in;
   logic [CNT_W-1:0] back_count_ff, back_count_in;
   logic [31:0]      fc32, bc32, pos32, total32;

   assign fc32    = 32'(front_count_ff);
   assign bc32    = 32'(back_count_ff);
   assign pos32   = 32'(req_position);
   assign total32 = fc32 + bc32;

   always_comb begin
      front_count_in     = front_count_ff;
      back_count_in      = back_count_ff;
      front_cmd          = '0;
      back_cmd           = '0;
      front_cmd.wr_addr  = ADDR_W'(front_count_ff);
      front_cmd.wr_data  = DATA_W'(req_value);
      back_cmd.wr_addr   = ADDR_W'(back_count_ff);
      back_cmd.wr_data   = DATA_W'(req_value);
      pend_in.use_mem    = 1'b0;
      pend_in.from_front = 1'b0;
      pend_in.status     = STATUS_OK;
      case (kind_type'(req_kind))
         KIND_PUSH_FRONT: begin
            if (fc32 >= STACK_DEPTH) begin
               pend_in.status = STATUS_FULL;
            end else begin
               front_cmd.wr_en = accept;
               front_count_in  = front_count_ff + CNT_W'(1);
            end
         end
         KIND_PUSH_BACK: begin
            if (bc32 >= STACK_DEPTH) begin
               pend_in.status = STATUS_FULL;
            end else begin
               back_cmd.wr_en = accept;
               back_count_in  = back_count_ff + CNT_W'(1);
            end
         end
         KIND_READ_INDEX: begin
            if (pos32 >= total32) begin
               pend_in.status = STATUS_RANGE;
            end else if (pos32 < fc32) begin
               pend_in.use_mem    = 1'b1;
               pend_in.from_front = 1'b1;
               front_cmd.rd_en    = accept;
               front_cmd.rd_addr  = ADDR_W'(fc32 - pos32 - 32'd1);
            end else begin
               pend_in.use_mem  = 1'b1;
               back_cmd.rd_en   = accept;
               back_cmd.rd_addr = ADDR_W'(pos32 - fc32);
            end
         end
         KIND_READ_FRONT: begin
            if (fc32 != 0) begin
               pend_in.use_mem    = 1'b1;
               pend_in.from_front = 1'b1;
               front_cmd.rd_en    = accept;
               front_cmd.rd_addr  = ADDR_W'(fc32 - 32'd1);
            end else if (bc32 != 0) begin
               pend_in.use_mem  = 1'b1;
               back_cmd.rd_en   = accept;
               back_cmd.rd_addr = '0;
            end else begin
               pend_in.status = STATUS_RANGE;
            end
         end
         KIND_READ_BACK: begin
            if (bc32 != 0) begin
               pend_in.use_mem  = 1'b1;
               back_cmd.rd_en   = accept;
               back_cmd.rd_addr = ADDR_W'(bc32 - 32'd1);
            end else if (fc32 != 0) begin
               pend_in.use_mem    = 1'b1;
               pend_in.from_front = 1'b1;
               front_cmd.rd_en    = accept;
               front_cmd.rd_addr  = '0;
            end else begin
               pend_in.status = STATUS_RANGE;
            end
         end
         default: begin
            pend_in.status = STATUS_RANGE;
         end
      endcase
      pend_in.count = TOT_W'(front_count_in) + TOT_W'(back_count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_count_ff <= '0;
         back_count_ff  <= '0;
      end else if (accept) begin
         front_count_ff <= front_count_in;
         back_count_ff  <= back_count_in;
      end
   end

endmodule

`default_nettype wire

### src/tsd_resp.sv
// Response side of the two-stack deque: holds the pending result for the
// memory read cycle and drives the output register. Uses tsd_pkg.
`default_nettype none

module tsd_resp (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           accept,
   input  tsd_pkg::pend_type                   pend_in,
   input  wire logic [tsd_pkg::DATA_W-1:0]     front_rd_data,
   input  wire logic [tsd_pkg::DATA_W-1:0]     back_rd_data,
   output logic                                req_ready,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [tsd_pkg::RDATA_W-1:0]         rsp_read_data,
   output logic [tsd_pkg::STATUS_W-1:0]        rsp_status,
   output logic [tsd_pkg::COUNT_W-1:0]         rsp_element_count,
   output logic                                rsp_is_empty
);

   import tsd_pkg::*;

   logic                 pend_valid_ff;
   pend_type             pend_ff;
   logic                 rsp_valid_ff;
   logic [RDATA_W-1:0]   read_data_ff, read_data_in;
   logic [STATUS_W-1:0]  status_ff;
   logic [COUNT_W-1:0]   count_ff;
   logic                 empty_ff;
   logic                 out_free;
   logic                 advance;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = pend_valid_ff && out_free;
   assign req_ready = !pend_valid_ff || out_free;

   always_comb begin
      read_data_in = '0;
      if (pend_ff.use_mem) begin
         read_data_in = pend_ff.from_front ? RDATA_W'(front_rd_data)
                                           : RDATA_W'(back_rd_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (accept) begin
            pend_valid_ff <= 1'b1;
         end else if (advance) begin
            pend_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_ff <= pend_in;
      end
      if (advance) begin
         read_data_ff <= read_data_in;
         status_ff    <= pend_ff.status;
         count_ff     <= COUNT_W'(pend_ff.count);
         empty_ff     <= (pend_ff.count == '0);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_data     = read_data_ff;
   assign rsp_status        = status_ff;
   assign rsp_element_count = count_ff;
   assign rsp_is_empty      = empty_ff;

endmodule

`default_nettype wire

### src/two_stack_deque.sv
// Top level of the two-stack deque: two stack memories, the request side
// and the response side. Uses tsd_pkg, tsd_ram, tsd_ctrl and tsd_resp.
//
// A request beat carries kind, value and position; each beat gives exactly
// one response beat with read_data, status, element_count and is_empty.
// Pushes write the front or back stack memory in the cycle the beat is
// taken; reads issue one memory read in that cycle. The read data and the
// pending result are registered at the accepting edge and move into the
// output register once it is free, which makes the response valid; a
// stalled receiver can hold them in the read stage first.
// The counts update as the beat is taken, so a new beat can be accepted
// every cycle while the receiver takes each response: the limit is the
// single read and write port of each stack memory, one access per beat.
// Reset clears both counts and the pipeline; the stack memories are not
// cleared and need no pass, since only written entries are ever read.
// When the receiver stalls, the response holds, one more result waits in
// the read stage, and req_ready drops until the output register frees.
`default_nettype none

module two_stack_deque (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [tsd_pkg::KIND_W-1:0]     req_kind,
   input  wire logic [tsd_pkg::VALUE_W-1:0]    req_value,
   input  wire logic [tsd_pkg::POS_W-1:0]      req_position,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [tsd_pkg::RDATA_W-1:0]         rsp_read_data,
   output logic [tsd_pkg::STATUS_W-1:0]        rsp_status,
   output logic [tsd_pkg::COUNT_W-1:0]         rsp_element_count,
   output logic                                rsp_is_empty
);

   import tsd_pkg::*;

   logic              accept;
   mem_cmd_type       front_cmd;
   mem_cmd_type       back_cmd;
   pend_type          pend_in;
   logic [DATA_W-1:0] front_rd_data;
   logic [DATA_W-1:0] back_rd_data;

   assign accept = req_valid && req_ready;

   tsd_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .req_kind     (req_kind),
      .req_value    (req_value),
      .req_position (req_position),
      .front_cmd    (front_cmd),
      .back_cmd     (back_cmd),
      .pend_in      (pend_in)
   );

   tsd_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_front_ram (
      .clock      (clock),
      .wr_en      (front_cmd.wr_en),
      .wr_addr    (front_cmd.wr_addr),
      .wr_data    (front_cmd.wr_data),
      .rd_en      (front_cmd.rd_en),
      .rd_addr    (front_cmd.rd_addr),
      .rd_data_ff (front_rd_data)
   );

   tsd_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_back_ram (
      .clock      (clock),
      .wr_en      (back_cmd.wr_en),
      .wr_addr    (back_cmd.wr_addr),
      .wr_data    (back_cmd.wr_data),
      .rd_en      (back_cmd.rd_en),
      .rd_addr    (back_cmd.rd_addr),
      .rd_data_ff (back_rd_data)
   );

   tsd_resp u_resp (
      .clock             (clock),
      .reset             (reset),
      .accept            (accept),
      .pend_in           (pend_in),
      .front_rd_data     (front_rd_data),
      .back_rd_data      (back_rd_data),
      .req_ready         (req_ready),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_read_data     (rsp_read_data),
      .rsp_status        (rsp_status),
      .rsp_element_count (rsp_element_count),
      .rsp_is_empty      (rsp_is_empty)
   );

endmodule

`default_nettype wire

### src/tsd_checker.sv
// Port-level checks for the two-stack deque, bound to the top level.
// Uses tsd_pkg.
`default_nettype none

module tsd_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic [tsd_pkg::RDATA_W-1:0]    rsp_read_data,
   input wire logic [tsd_pkg::STATUS_W-1:0]   rsp_status,
   input wire logic [tsd_pkg::COUNT_W-1:0]    rsp_element_count,
   input wire logic                           rsp_is_empty
);

   import tsd_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data)
         && $stable(rsp_status) && $stable(rsp_element_count))
      else $error("response beat changed while stalled");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == (rsp_element_count == '0)))
      else $error("empty flag disagrees with element count");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_read_data == '0)
      else $error("error response carries nonzero data");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FULL
         |-> 32'(rsp_element_count) >= STACK_DEPTH)
      else $error("full status with a stack below capacity");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind two_stack_deque tsd_checker u_tsd_checker (.*);

`default_nettype wire
